### hw/rtl/bpr_pkg.sv
// bpr_pkg: opcodes, window slot types and the rewrite function
// shared by the bytecode peephole rewriter cells and top level
// depends on nothing
package bpr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned NumCells = 4;

  localparam logic [ByteW-1:0] OpNop   = 8'h00;
  localparam logic [ByteW-1:0] OpOne   = 8'h01;
  localparam logic [ByteW-1:0] OpLoad  = 8'h02;
  localparam logic [ByteW-1:0] OpStore = 8'h03;
  localparam logic [ByteW-1:0] OpAdd   = 8'h10;
  localparam logic [ByteW-1:0] OpMul   = 8'h12;
  localparam logic [ByteW-1:0] OpPush  = 8'h60;
  localparam logic [ByteW-1:0] OpPop   = 8'h61;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             valid;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic accept;
  } cell_ctrl_t;

  typedef struct packed {
    logic [ByteW-1:0] data0;
    logic [ByteW-1:0] data1;
    logic [ByteW-1:0] data2;
  } rw_t;

  // rules at the head of the window; v1/v3 tell whether bytes 1 and 3 are in the stream
  function automatic rw_t rewrite_head(logic [ByteW-1:0] b0, logic [ByteW-1:0] b1,
                                       logic [ByteW-1:0] b2, logic [ByteW-1:0] b3,
                                       logic v1, logic v3);
    rw_t r;
    r.data0 = b0;
    r.data1 = b1;
    r.data2 = b2;
    if (v1 && r.data0 == OpPush && r.data1 == OpPop) begin
      r.data0 = OpNop;
      r.data1 = OpNop;
    end
    if (v3 && r.data0 == OpLoad && r.data2 == OpStore && r.data1 == b3) begin
      r.data0 = OpNop;
      r.data2 = OpNop;
    end
    if (v1 && r.data0 == OpAdd && r.data1 == OpNop) begin
      r.data0 = OpNop;
    end
    if (v1 && r.data0 == OpMul && r.data1 == OpOne) begin
      r.data0 = OpNop;
    end
    return r;
  endfunction

endpackage

### hw/rtl/bytecode_peephole_rewriter.sv
// bytecode_peephole_rewriter: four-cell window with peephole rules at its head
// the head byte enters the output register once the window is full or holds the end beat
// throughput: one byte per cycle while the output is free; after an end_of_stream beat
// the input stalls until the window has drained, one byte per cycle as the output allows
// reset: asynchronous active low, empties the window and the output register
// depends on bpr_pkg and bpr_cell
module bytecode_peephole_rewriter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [bpr_pkg::ByteW-1:0] data_byte_i,
  input  logic                     end_of_stream_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [bpr_pkg::ByteW-1:0] out_byte_o,
  output logic                     out_last_o
);
  import bpr_pkg::*;

  slot_t      slot [NumCells];
  slot_t      right [NumCells];
  logic       left_valid [NumCells];
  slot_t      load;
  cell_ctrl_t ctrl;
  rw_t        rw;
  logic       has_last;
  logic       head_ok;
  logic       out_free;
  logic       emit;
  logic       accept;

  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q;
  logic             out_last_q;

  always_comb begin
    has_last = 1'b0;
    for (int i = 0; i < NumCells; i++) begin
      has_last = has_last | (slot[i].valid & slot[i].last);
    end
  end

  assign rw = rewrite_head(slot[0].data, slot[1].data, slot[2].data, slot[3].data,
                           slot[1].valid, slot[3].valid);

  assign head_ok  = slot[0].valid && (slot[NumCells-1].valid || has_last);
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = head_ok && out_free;

  assign in_stall_o = has_last || (slot[NumCells-1].valid && !emit);
  assign accept     = in_valid_i && !in_stall_o;

  assign ctrl = '{shift: emit, accept: accept};
  assign load = '{data: data_byte_i, last: end_of_stream_i, valid: 1'b1};

  // cells 1 and 2 may be rewritten by the head rules as they shift down
  always_comb begin
    right[0] = '{data: rw.data1, last: slot[1].last, valid: slot[1].valid};
    right[1] = '{data: rw.data2, last: slot[2].last, valid: slot[2].valid};
    right[2] = slot[3];
    right[3] = '0;
    left_valid[0] = 1'b1;
    for (int i = 1; i < NumCells; i++) begin
      left_valid[i] = slot[i-1].valid;
    end
  end

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    bpr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .left_valid_i (left_valid[g]),
      .right_i      (right[g]),
      .load_i       (load),
      .slot_o       (slot[g])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= rw.data0;
      out_last_q <= slot[0].last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

### hw/rtl/bpr_cell.sv
// bpr_cell: one window position, holds a byte with its valid and last marks
// takes its right neighbor on a shift, or the incoming beat when it is the fill slot
// depends on bpr_pkg
module bpr_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bpr_pkg::cell_ctrl_t ctrl_i,
  input  logic               left_valid_i,
  input  bpr_pkg::slot_t     right_i,
  input  bpr_pkg::slot_t     load_i,
  output bpr_pkg::slot_t     slot_o
);
  import bpr_pkg::*;

  logic             valid_q, valid_d;
  logic             last_q, last_d;
  logic [ByteW-1:0] data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    last_d  = last_q;
    data_d  = data_q;
    priority if (ctrl_i.shift && right_i.valid) begin
      valid_d = 1'b1;
      last_d  = right_i.last;
      data_d  = right_i.data;
    end else if (ctrl_i.shift && ctrl_i.accept && valid_q) begin
      valid_d = 1'b1;
      last_d  = load_i.last;
      data_d  = load_i.data;
    end else if (ctrl_i.shift) begin
      valid_d = 1'b0;
    end else if (ctrl_i.accept && !valid_q && left_valid_i) begin
      valid_d = 1'b1;
      last_d  = load_i.last;
      data_d  = load_i.data;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    data_q <= data_d;
  end

  assign slot_o = '{data: data_q, last: last_q, valid: valid_q};

endmodule

### hw/rtl/bpr_checker.sv
// bpr_checker: port-level checks for the bytecode peephole rewriter
// bound to bytecode_peephole_rewriter; depends on bpr_pkg
module bpr_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic [bpr_pkg::ByteW-1:0] data_byte_i,
  input logic                     end_of_stream_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [bpr_pkg::ByteW-1:0] out_byte_o,
  input logic                     out_last_o
);
  import bpr_pkg::*;

  // output register is empty while reset is held
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // an end beat blocks the input while the window drains
  a_drain_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_stream_i |=> in_stall_o)
    else $error("input taken right after end beat");

  // a stalled input beat is held by the sender
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable(data_byte_i) && $stable(end_of_stream_i))
    else $error("stalled input beat changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_byte_o) && $stable(out_last_o))
    else $error("stalled output beat changed");

endmodule

bind bytecode_peephole_rewriter bpr_checker u_bpr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .data_byte_i     (data_byte_i),
  .end_of_stream_i (end_of_stream_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_byte_o      (out_byte_o),
  .out_last_o      (out_last_o)
);
